// ----- rtl/core/dps_pkg.sv -----
`timescale 1ns / 1ps
package dps_pkg;
  typedef struct packed {
    logic [1:0] kind;
    logic signed [15:0] load_x;
    logic signed [15:0] load_y;
    logic signed [15:0] load_vx;
    logic signed [15:0] load_vy;
    logic signed [15:0] load_vz;
    logic [7:0] load_life;
    logic load_chunk;
    logic solid_answer;
  } in_item_t;

  typedef struct packed {
    logic result_kind;
    logic signed [11:0] query_x;
    logic signed [11:0] query_y;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_z;
    logic is_active;
    logic is_grounded;
  } out_item_t;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_ANSWER = 2'd2;
  localparam logic RES_QUERY = 1'b0;
  localparam logic RES_REPORT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_TICK_OFF, ST_REPORT_ONLY, ST_QX, ST_ANS_X, ST_QY, ST_ANS_Y,
    ST_Z, ST_BOUNCE, ST_DRAG, ST_SETTLE, ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_QX, OP_ANS_X, OP_QY, OP_ANS_Y, OP_MOVE_XY, OP_Z,
    OP_BOUNCE, OP_DRAG, OP_SETTLE, OP_REPORT
  } op_t;

  typedef struct packed {
    op_t op;
    logic solid;
  } cmd_t;

  typedef struct packed {
    logic active;
    logic bounce;
  } status_t;
endpackage

// ----- rtl/core/dps_datapath.sv -----
`timescale 1ns / 1ps
module dps_datapath #(
  parameter int FRACTION_BITS = 4
) (
  input  logic clk,
  input  dps_pkg::cmd_t cmd,
  input  dps_pkg::in_item_t load_item,
  input  logic rst_n,
  output dps_pkg::status_t status,
  output dps_pkg::out_item_t result
);
  import dps_pkg::*;

  logic signed [15:0] px_r, py_r, pz_r, vx_r, vy_r, vz_r;
  logic [7:0] life_r, settle_r;
  logic chunk_r, gnd_r, act_r, gnd0_r;
  logic signed [11:0] qx_r, qy_r;
  logic rk_r;

  function automatic logic signed [15:0] damp(input logic signed [15:0] v,
                                              input logic [3:0] n);
    logic [15:0] mag;
    logic [19:0] p;
    logic [15:0] sc;
    begin
      mag = v[15] ? 16'(-v) : v;
      p = 20'(mag) * 20'(n);
      sc = p[19:4];
      damp = v[15] ? 16'(-sc) : sc;
    end
  endfunction

  function automatic logic signed [11:0] cell_of(input logic signed [15:0] v);
    logic signed [15:0] s;
    begin
      s = v >>> FRACTION_BITS;
      cell_of = s[11:0];
    end
  endfunction

  logic signed [15:0] nx, ny, nz, nvz;
  logic [3:0] rest, drag;
  logic signed [15:0] dvx, dvy;
  assign nx = px_r + vx_r;
  assign ny = py_r + vy_r;
  assign nz = pz_r + vz_r;
  assign nvz = vz_r - 16'sd3;
  assign rest = chunk_r ? 4'd11 : 4'd7;
  assign drag = gnd0_r ? (chunk_r ? 4'd13 : 4'd10) : (chunk_r ? 4'd15 : 4'd13);
  assign dvx = damp(vx_r, drag);
  assign dvy = damp(vy_r, drag);

  assign status.active = act_r;
  assign status.bounce = chunk_r && (vz_r < -16'sd10);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r <= '0; py_r <= '0; pz_r <= '0; vx_r <= '0; vy_r <= '0; vz_r <= '0;
      life_r <= '0; settle_r <= '0; chunk_r <= 1'b0; gnd_r <= 1'b0;
      act_r <= 1'b0; gnd0_r <= 1'b0; qx_r <= '0; qy_r <= '0; rk_r <= RES_REPORT;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          px_r <= load_item.load_x; py_r <= load_item.load_y; pz_r <= '0;
          vx_r <= load_item.load_vx; vy_r <= load_item.load_vy;
          vz_r <= load_item.load_vz; life_r <= load_item.load_life;
          chunk_r <= load_item.load_chunk; gnd_r <= 1'b0; settle_r <= '0;
          act_r <= 1'b1; rk_r <= RES_REPORT; qx_r <= '0; qy_r <= '0;
        end
        OP_QX: begin
          gnd0_r <= gnd_r; rk_r <= RES_QUERY; qx_r <= cell_of(nx); qy_r <= cell_of(py_r);
        end
        OP_ANS_X: begin
          if (cmd.solid) begin
            vx_r <= 16'(-damp(vx_r, rest));
            qx_r <= cell_of(px_r);
          end else begin
            px_r <= nx;
            qx_r <= cell_of(nx);
          end
          qy_r <= cell_of(ny); rk_r <= RES_QUERY;
        end
        OP_ANS_Y: begin
          if (cmd.solid) vy_r <= 16'(-damp(vy_r, rest));
          else py_r <= ny;
        end
        OP_MOVE_XY: begin
          gnd0_r <= gnd_r; px_r <= nx; py_r <= ny;
        end
        OP_Z: begin
          if (!gnd_r) begin
            if ((nz[15] || nz == 16'sd0) && nvz[15]) begin
              pz_r <= '0;
              vz_r <= nvz;
            end else begin
              pz_r <= nz;
              vz_r <= nvz;
            end
          end
        end
        OP_BOUNCE: begin
          // Runs only when the particle hit the ground while airborne.
          if (chunk_r && vz_r < -16'sd10) begin
            vz_r <= 16'(-damp(vz_r, 4'd5));
            vx_r <= damp(vx_r, 4'd13);
            vy_r <= damp(vy_r, 4'd13);
          end else begin
            vz_r <= '0;
            gnd_r <= 1'b1;
          end
        end
        OP_DRAG: begin
          vx_r <= dvx; vy_r <= dvy;
          if (life_r != 8'd0) life_r <= life_r - 8'd1;
        end
        OP_SETTLE: begin
          if (gnd_r && vx_r > -16'sd2 && vx_r < 16'sd2 && vy_r > -16'sd2
              && vy_r < 16'sd2) begin
            vx_r <= '0; vy_r <= '0;
            if (settle_r != 8'd255) settle_r <= settle_r + 8'd1;
            if (life_r == 8'd0 || settle_r >= 8'd24) act_r <= 1'b0;
          end else begin
            settle_r <= '0;
            if (life_r == 8'd0) act_r <= 1'b0;
          end
        end
        OP_REPORT: begin
          rk_r <= RES_REPORT; qx_r <= '0; qy_r <= '0;
        end
        default: ;
      endcase
    end
  end

  assign result = '{result_kind: rk_r, query_x: qx_r, query_y: qy_r,
                    pos_x: px_r, pos_y: py_r, pos_z: pz_r, vel_x: vx_r, vel_y: vy_r,
                    vel_z: vz_r, is_active: act_r, is_grounded: gnd_r};
endmodule

// ----- rtl/core/dps_ctrl.sv -----
`timescale 1ns / 1ps
module dps_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  dps_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_stall,
  input  logic coll_en,
  input  logic z_hit,
  input  dps_pkg::status_t status,
  output dps_pkg::cmd_t cmd
);
  import dps_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_WX, PH_WY} phase_t;
  state_t st_r, st_nxt;
  phase_t ph_r, ph_nxt;
  logic ov_r, ov_nxt, busy;
  logic acc;

  assign busy = (st_r != ST_IDLE);
  assign in_stall = busy || ov_r;
  assign acc = in_valid && !in_stall;
  assign out_valid = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; ph_r <= PH_IDLE; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ph_r <= ph_nxt; ov_r <= ov_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r; ph_nxt = ph_r; ov_nxt = ov_r && out_stall;
    cmd.op = OP_NONE; cmd.solid = in_data.solid_answer;
    case (st_r)
      ST_IDLE: begin
        if (acc) begin
          case (in_data.kind)
            KIND_LOAD: begin
              cmd.op = OP_LOAD; ph_nxt = PH_IDLE; ov_nxt = 1'b1;
            end
            KIND_TICK: begin
              if (ph_r == PH_IDLE) begin
                if (!status.active) begin
                  cmd.op = OP_REPORT; ov_nxt = 1'b1;
                end else if (coll_en) begin
                  cmd.op = OP_QX; ph_nxt = PH_WX; ov_nxt = 1'b1;
                end else begin
                  cmd.op = OP_MOVE_XY; st_nxt = ST_Z;
                end
              end
            end
            KIND_ANSWER: begin
              if (ph_r == PH_WX) begin
                cmd.op = OP_ANS_X; ph_nxt = PH_WY; ov_nxt = 1'b1;
              end else if (ph_r == PH_WY) begin
                cmd.op = OP_ANS_Y; ph_nxt = PH_IDLE; st_nxt = ST_Z;
              end
            end
            default: ;
          endcase
        end
      end
      ST_Z: begin
        cmd.op = OP_Z; st_nxt = ST_BOUNCE;
      end
      ST_BOUNCE: begin
        if (z_hit) cmd.op = OP_BOUNCE;
        st_nxt = ST_DRAG;
      end
      ST_DRAG: begin
        cmd.op = OP_DRAG; st_nxt = ST_SETTLE;
      end
      ST_SETTLE: begin
        cmd.op = OP_SETTLE; st_nxt = ST_OUT;
      end
      ST_OUT: begin
        cmd.op = OP_REPORT; ov_nxt = 1'b1; st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end
endmodule

// ----- rtl/core/debris_particle_step_top.sv -----
`timescale 1ns / 1ps
// Debris particle step block.
// Input channel in_valid/in_stall/in_data carries load, tick and solid-answer
// items; the result channel out_valid/out_stall/out_data carries collision
// queries and state reports. Each transfer completes when valid is high and
// stall is low.
// A load, a tick on an inactive particle, and a tick or first answer that
// produces a query give their result in the cycle after the input transfer.
// A tick without collisions, or the second answer, runs the sequence height,
// bounce, drag, settle and report, and then gives its state report.
// Items that give no result are accepted and dropped.
// The result is held in an output register; no new input is taken until it is
// transferred, so a stalled receiver holds off the input side.
// Reset clears the particle to inactive, collisions enabled, and no result.
// cfg_we writes collisions_enabled from cfg_wdata.
module debris_particle_step_top #(
  parameter int FRACTION_BITS = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  dps_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output dps_pkg::out_item_t out_data,
  input  logic cfg_we,
  input  logic cfg_wdata
);
  import dps_pkg::*;

  logic coll_en_r, zhit_r;
  cmd_t cmd;
  status_t status;
  out_item_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) coll_en_r <= 1'b1;
    else if (cfg_we) coll_en_r <= cfg_wdata;
  end

  // Ground contact is decided from the state before the height update.
  always_ff @(posedge clk) begin
    if (!rst_n) zhit_r <= 1'b0;
    else zhit_r <= !res.is_grounded && (res.pos_z + res.vel_z <= 16'sd0)
                   && (res.vel_z - 16'sd3 < 16'sd0);
  end

  dps_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .coll_en(coll_en_r), .z_hit(zhit_r), .status(status), .cmd(cmd)
  );

  dps_datapath #(.FRACTION_BITS(FRACTION_BITS)) u_dp (
    .clk(clk), .cmd(cmd), .load_item(in_data), .rst_n(rst_n),
    .status(status), .result(res)
  );

  assign out_data = res;
endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import dps_pkg::*;

  localparam int IDLE_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  debris_particle_step_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef enum logic [1:0] {PH_IDLE, PH_WAIT_X, PH_WAIT_Y} phase_t;

  logic coll_en;
  logic signed [15:0] px, py, pz, vx, vy, vz;
  logic [7:0] life, settle;
  logic chunk, grounded, active;
  phase_t phase;

  out_item_t expected_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int items_sent = 0;
  bit gaps_on = 1'b1;

  function automatic logic signed [11:0] cell_of(input logic signed [15:0] v);
    logic signed [15:0] s;
    s = v >>> 4;
    return s[11:0];
  endfunction

  function automatic logic signed [15:0] damp(input logic signed [15:0] v,
                                              input int unsigned n);
    int unsigned mag, sc;
    int sv;
    sv = v;
    if (v == 0 || n == 0) return 16'sd0;
    mag = (sv < 0) ? -sv : sv;
    sc = (mag * n) >> 4;
    return (sv < 0) ? 16'(-sc) : 16'(sc);
  endfunction

  function automatic out_item_t state_item(input logic rk, input logic signed [11:0] qx,
                                           input logic signed [11:0] qy);
    out_item_t o;
    o.result_kind = rk; o.query_x = qx; o.query_y = qy;
    o.pos_x = px; o.pos_y = py; o.pos_z = pz;
    o.vel_x = vx; o.vel_y = vy; o.vel_z = vz;
    o.is_active = active; o.is_grounded = grounded;
    return o;
  endfunction

  task automatic finish_frame();
    int unsigned drag;
    int ax, ay;
    drag = grounded ? (chunk ? 13 : 10) : (chunk ? 15 : 13);
    if (!grounded) begin
      pz = pz + vz;
      vz = vz - 16'sd3;
      if (pz <= 0 && vz < 0) begin
        pz = 0;
        if (chunk && vz < -16'sd10) begin
          vz = -damp(vz, 5);
          vx = damp(vx, 13);
          vy = damp(vy, 13);
        end else begin
          vz = 0;
          grounded = 1'b1;
        end
      end
    end
    vx = damp(vx, drag);
    vy = damp(vy, drag);
    if (life != 0) life = life - 1;
    ax = vx; ay = vy;
    if (grounded && ax < 2 && ax > -2 && ay < 2 && ay > -2) begin
      vx = 0; vy = 0;
      if (settle < 255) settle = settle + 1;
    end else begin
      settle = 0;
    end
    if (life == 0 || settle > 24) active = 1'b0;
  endtask

  task automatic predict(input in_item_t it);
    case (it.kind)
      KIND_LOAD: begin
        px = it.load_x; py = it.load_y; pz = 0;
        vx = it.load_vx; vy = it.load_vy; vz = it.load_vz;
        life = it.load_life; chunk = it.load_chunk;
        grounded = 0; settle = 0; active = 1; phase = PH_IDLE;
        expected_q.push_back(state_item(RES_REPORT, 0, 0));
      end
      KIND_TICK: begin
        if (phase != PH_IDLE) return;
        if (!active) begin
          expected_q.push_back(state_item(RES_REPORT, 0, 0));
        end else if (coll_en) begin
          phase = PH_WAIT_X;
          expected_q.push_back(state_item(RES_QUERY, cell_of(px + vx), cell_of(py)));
        end else begin
          px = px + vx; py = py + vy;
          finish_frame();
          expected_q.push_back(state_item(RES_REPORT, 0, 0));
        end
      end
      KIND_ANSWER: begin
        if (phase == PH_WAIT_X) begin
          if (it.solid_answer) vx = -damp(vx, chunk ? 11 : 7);
          else px = px + vx;
          phase = PH_WAIT_Y;
          expected_q.push_back(state_item(RES_QUERY, cell_of(px), cell_of(py + vy)));
        end else if (phase == PH_WAIT_Y) begin
          if (it.solid_answer) vy = -damp(vy, chunk ? 11 : 7);
          else py = py + vy;
          phase = PH_IDLE;
          finish_frame();
          expected_q.push_back(state_item(RES_REPORT, 0, 0));
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input in_item_t it);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    predict(it);
    items_sent++;
  endtask

  function automatic in_item_t rand_noise();
    in_item_t it;
    logic [95:0] r;
    r = {$urandom, $urandom, $urandom};
    it = r[$bits(in_item_t)-1:0];
    return it;
  endfunction

  function automatic in_item_t make_load(input int life_max);
    in_item_t it;
    it = rand_noise();
    it.kind = KIND_LOAD;
    case ($urandom_range(0, 3))
      0: begin
        it.load_vx = $signed(16'($urandom_range(0, 80))) - 16'sd40;
        it.load_vy = $signed(16'($urandom_range(0, 80))) - 16'sd40;
        it.load_vz = $signed(16'($urandom_range(0, 60))) - 16'sd10;
      end
      1: begin
        it.load_vx = $signed(16'($urandom_range(0, 6))) - 16'sd3;
        it.load_vy = $signed(16'($urandom_range(0, 6))) - 16'sd3;
        it.load_vz = $signed(16'($urandom_range(0, 8)));
      end
      default: ;
    endcase
    it.load_life = 8'($urandom_range(1, life_max));
    return it;
  endfunction

  function automatic in_item_t make_simple(input logic [1:0] k, input logic sol);
    in_item_t it;
    it = rand_noise();
    it.kind = k;
    it.solid_answer = sol;
    return it;
  endfunction

  task automatic frame();
    send_item(make_simple(KIND_TICK, 1'b0));
    if (phase != PH_IDLE) begin
      send_item(make_simple(KIND_ANSWER, 1'($urandom_range(0, 1))));
      send_item(make_simple(KIND_ANSWER, 1'($urandom_range(0, 1))));
    end
  endtask

  task automatic drain_and_config(input logic val);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    coll_en = val;
  endtask

  task automatic test_directed();
    in_item_t it;
    send_item(make_simple(KIND_TICK, 1'b0));
    send_item(make_simple(KIND_ANSWER, 1'b1));
    send_item(make_simple(2'd3, 1'b0));
    it = '0; it.kind = KIND_LOAD;
    it.load_x = 16'sh7fff; it.load_y = -16'sh8000; it.load_vx = 16'sh7fff;
    it.load_vy = -16'sh8000; it.load_vz = 16'sh7fff; it.load_life = 8'hff;
    it.load_chunk = 1'b1;
    send_item(it);
    send_item(make_simple(KIND_TICK, 1'b0));
    send_item(make_simple(KIND_TICK, 1'b0));
    send_item(make_simple(KIND_ANSWER, 1'b1));
    send_item(make_simple(KIND_ANSWER, 1'b1));
    send_item(make_simple(KIND_TICK, 1'b0));
    send_item(make_simple(KIND_ANSWER, 1'b0));
    it.load_chunk = 1'b0; it.load_x = -16'sh8000; it.load_vx = -16'sh8000;
    it.load_vz = -16'sh8000; it.load_life = 8'd1;
    send_item(it);
    send_item(make_simple(KIND_TICK, 1'b0));
    send_item(make_simple(KIND_ANSWER, 1'b0));
    send_item(make_simple(KIND_ANSWER, 1'b0));
    send_item(make_simple(KIND_TICK, 1'b0));
    it = '0; it.kind = KIND_LOAD; it.load_vz = 16'sd30; it.load_life = 8'd0;
    it.load_chunk = 1'b1; it.load_vx = 16'sd1;
    send_item(it);
    frame();
    frame();
  endtask

  task automatic test_no_collisions();
    drain_and_config(1'b0);
    repeat (6) begin
      send_item(make_load(255));
      repeat ($urandom_range(5, 40)) send_item(make_simple(KIND_TICK, 1'b0));
    end
  endtask

  task automatic test_random(input int n);
    int start;
    start = items_sent;
    while (items_sent - start < n) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(rand_noise());
      end else begin
        send_item(make_load($urandom_range(0, 1) ? 255 : 40));
        repeat ($urandom_range(1, 30)) begin
          if (items_sent - start >= n) break;
          frame();
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) idle_cycles <= 0;
      else if (out_valid && !out_stall) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    out_item_t exp_item;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, out_data);
        errors++;
      end else begin
        exp_item = expected_q.pop_front();
        if (exp_item !== out_data) begin
          $display("%0t mismatch expected %h actual %h", $time, exp_item, out_data);
          errors++;
        end
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (!gaps_on) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 18);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    coll_en = 1'b1;
    px = 0; py = 0; pz = 0; vx = 0; vy = 0; vz = 0;
    life = 0; settle = 0; chunk = 0; grounded = 0; active = 0; phase = PH_IDLE;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_no_collisions();
    drain_and_config(1'b1);
    test_random(950);
    drain_and_config(1'b0);
    test_random(250);
    drain_and_config(1'b1);
    gaps_on = 1'b0;
    test_random(300);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
